[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the inverse frequency core.
// Needs a clock named clock and an active high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check while out of reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check on every edge, reset included
`define ASSERT_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`endif

[rtl/core/yrif_pkg.sv]
// Package of the inverse frequency core: widths, register codes, constants
// and the elaboration-time coefficient function of the exp2 stages.
package yrif_pkg;

   localparam int FRAC_W       = 30;
   localparam int LG_W         = 35;
   localparam int IDX_W        = 7;
   localparam int PROD_W       = 43;
   localparam int HD_W         = 9;
   localparam int THETA_W      = 24;
   localparam int Q8_W         = 16;
   localparam int OC_W         = 21;
   localparam int BASE_W       = 33;
   localparam int ROT_W        = 28;
   localparam int OUT_W        = 32;
   localparam int EXPN_W       = 13;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;
   localparam int MAX_HDIM     = 256;
   localparam int ONE_Q8       = 256;

   localparam logic [29:0] INV_TWO_PI = 30'd683565276;

   localparam logic [HD_W-1:0]    RST_HDIM      = 9'd128;
   localparam logic [THETA_W-1:0] RST_THETA     = 24'd10000;
   localparam logic [Q8_W-1:0]    RST_SCALE     = 16'd256;
   localparam logic [Q8_W-1:0]    RST_ROT_HI    = 16'd8192;
   localparam logic [Q8_W-1:0]    RST_ROT_LO    = 16'd256;
   localparam logic [OC_W-1:0]    RST_ORIG_CTX  = 21'd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HDIM          = 3'd0,
      REG_THETA         = 3'd1,
      REG_CONTEXT_SCALE = 3'd2,
      REG_ROT_HI        = 3'd3,
      REG_ROT_LO        = 3'd4,
      REG_ORIG_CONTEXT  = 3'd5
   } csr_reg_type;

   typedef enum logic [1:0] {
      MODE_KEEP,
      MODE_LIN,
      MODE_BLEND
   } mode_type;

   function automatic logic [31:0] yrif_isqrt(input logic [63:0] x_arg);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_arg;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (b > x) begin
            b = b >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r[31:0];
   endfunction

   // c_k = 2^(-2^-k) in Q0.32
   function automatic logic [31:0] yrif_exp_coef(input int k);
      logic [31:0] c;
      c = yrif_isqrt(64'h8000_0000_0000_0000);
      for (int j = 1; j < k; j++) begin
         c = yrif_isqrt({c, 32'h0});
      end
      return c;
   endfunction

endpackage

[rtl/core/yrif_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Used by the inverse frequency core; no package dependency.
module yrif_div #(
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 8,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [NUM_W-1:0]  acc_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic              valid_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [NUM_W-1:0]  acc_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  acc_in;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign acc_prev   = in_num;
         assign den_prev   = in_den;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign acc_prev   = acc_ff[s-1];
         assign den_prev   = den_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      always_comb begin
         trial  = {rem_prev, acc_prev[NUM_W-1]};
         ge     = (trial >= {1'b0, den_prev});
         rem_in = ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
         acc_in = {acc_prev[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            acc_ff[s]  <= acc_in;
            den_ff[s]  <= den_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = acc_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

[rtl/core/yarn_rope_inverse_frequency_core.sv]
// Inverse frequency generator for rotary position tables with context scaling.
// Channels: req_ carries one frequency pair index a beat, rsp_ returns its
// inverse frequency in unsigned Q1.31, one beat per request, in order.
// csr_ writes the six configuration registers; csr_ready is always high.
// Throughput: one beat per cycle while req_tready is high. Between request beat
// and rsp_tvalid lie three bit-serial divider pipelines (43, 41, 49 stages)
// and thirty exp2 multiply stages.
// log2(theta) is formed by one squaring unit after reset and after each
// theta write: req_tready stays low while it runs.
// Reset loads the register defaults and empties the pipeline.
// When the receiver stalls, an output register and one skid entry hold
// results; the pipeline freezes once the skid entry fills, and req_tready
// drops with it.
`include "assert_macros.svh"

module yarn_rope_inverse_frequency_core #(
   parameter int MAX_HD = yrif_pkg::MAX_HDIM
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [6:0] freq_index
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [yrif_pkg::OUT_W-1:0]      rsp_tdata,   // [31:0] recip_freq
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [yrif_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [yrif_pkg::CSR_DATA_W-1:0] csr_data
);
   import yrif_pkg::*;

   typedef enum logic [1:0] {LG_IDLE, LG_LOAD, LG_RUN} lg_state_type;

   localparam int DIVB_NUM_W  = BASE_W + 8;
   localparam int DIVB_SIDE_W = BASE_W + ROT_W;
   localparam int DIVC_NUM_W  = BASE_W + Q8_W;
   localparam int DIVC_SIDE_W = 2 + 2 * BASE_W;

   // configuration
   logic [HD_W-1:0]    hdim_ff;
   logic [THETA_W-1:0] theta_ff;
   logic [Q8_W-1:0]    scale_ff;
   logic [Q8_W-1:0]    rot_hi_ff;
   logic [Q8_W-1:0]    rot_lo_ff;
   logic [OC_W-1:0]    orig_ctx_ff;
   logic               theta_wr;

   assign csr_ready = 1'b1;
   assign theta_wr  = csr_valid && (csr_reg_type'(csr_index) == REG_THETA);

   always_ff @(posedge clock) begin
      if (reset) begin
         hdim_ff     <= RST_HDIM;
         theta_ff    <= RST_THETA;
         scale_ff    <= RST_SCALE;
         rot_hi_ff   <= RST_ROT_HI;
         rot_lo_ff   <= RST_ROT_LO;
         orig_ctx_ff <= RST_ORIG_CTX;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_HDIM:          hdim_ff     <= HD_W'(csr_data);
            REG_THETA:         theta_ff    <= csr_data;
            REG_CONTEXT_SCALE: scale_ff    <= Q8_W'(csr_data);
            REG_ROT_HI:        rot_hi_ff   <= Q8_W'(csr_data);
            REG_ROT_LO:        rot_lo_ff   <= Q8_W'(csr_data);
            REG_ORIG_CONTEXT:  orig_ctx_ff <= OC_W'(csr_data);
            default: ;
         endcase
      end
   end

   // log2(theta) squaring unit
   lg_state_type      lg_state_ff;
   logic [4:0]        lg_cnt_ff;
   logic [4:0]        lg_e_ff;
   logic [30:0]       lg_m_ff;
   logic [FRAC_W-1:0] lg_frac_ff;
   logic [LG_W-1:0]   lg_ff;
   logic [4:0]        msb_pos;
   logic [30:0]       m_init;
   logic [61:0]       m_sq;
   logic [31:0]       m_next;

   always_comb begin
      msb_pos = '0;
      for (int i = 0; i < THETA_W; i++) begin
         if (theta_ff[i]) begin
            msb_pos = 5'(i);
         end
      end
      m_init = 31'(theta_ff) << (5'd30 - msb_pos);
      m_sq   = 62'(lg_m_ff) * 62'(lg_m_ff);
      m_next = m_sq[61:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_state_ff <= LG_LOAD;
         lg_cnt_ff   <= '0;
      end else if (theta_wr) begin
         lg_state_ff <= LG_LOAD;
      end else begin
         case (lg_state_ff)
            LG_LOAD: begin
               lg_cnt_ff <= '0;
               if (theta_ff < THETA_W'(2)) begin
                  lg_ff       <= '0;
                  lg_state_ff <= LG_IDLE;
               end else begin
                  lg_e_ff     <= msb_pos;
                  lg_m_ff     <= m_init;
                  lg_frac_ff  <= '0;
                  lg_state_ff <= LG_RUN;
               end
            end
            LG_RUN: begin
               lg_frac_ff <= {lg_frac_ff[FRAC_W-2:0], m_next[31]};
               lg_m_ff    <= m_next[31] ? m_next[31:1] : m_next[30:0];
               lg_cnt_ff  <= lg_cnt_ff + 5'd1;
               if (lg_cnt_ff == 5'(FRAC_W - 1)) begin
                  lg_ff       <= {lg_e_ff, lg_frac_ff[FRAC_W-2:0], m_next[31]};
                  lg_state_ff <= LG_IDLE;
               end
            end
            LG_IDLE: ;
            default: lg_state_ff <= LG_LOAD;
         endcase
      end
   end

   // pipeline control
   logic en;
   logic skid_valid_ff;
   assign en         = !skid_valid_ff;
   assign req_tready = en && (lg_state_ff == LG_IDLE);

   // accept and exponent product
   logic             a_valid_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             b_valid_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [HD_W-1:0]  d_ff;
   logic             dz_ff;
   logic [HD_W-1:0]  d_in;

   assign d_in = ({2'b0, hdim_ff} > 11'(MAX_HD)) ? HD_W'(MAX_HD) : hdim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid && req_tready;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff  <= req_tdata[IDX_W-1:0];
         prod_ff <= PROD_W'(lg_ff) * PROD_W'({idx_ff, 1'b0});
         d_ff    <= d_in;
         dz_ff   <= (d_in == '0);
      end
   end

   logic              da_valid;
   logic [PROD_W-1:0] da_quo;
   logic              da_dz;

   yrif_div #(.NUM_W(PROD_W), .DEN_W(HD_W), .SIDE_W(1)) u_div_exp (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (b_valid_ff),
      .in_num   (prod_ff),
      .in_den   (d_ff),
      .in_side  (dz_ff),
      .out_valid(da_valid),
      .out_quo  (da_quo),
      .out_side (da_dz)
   );

   // exp2 stages
   logic              ex_valid_ff [FRAC_W];
   logic [BASE_W-1:0] ex_p_ff     [FRAC_W];
   logic [EXPN_W-1:0] ex_n_ff     [FRAC_W];
   logic [FRAC_W-1:0] ex_f_ff     [FRAC_W];

   for (genvar k = 0; k < FRAC_W; k++) begin : g_exp
      localparam logic [31:0] COEF = yrif_exp_coef(k + 1);
      logic              valid_prev;
      logic [BASE_W-1:0] p_prev;
      logic [EXPN_W-1:0] n_prev;
      logic [FRAC_W-1:0] f_prev;
      logic [64:0]       mul;
      logic [BASE_W-1:0] p_in;

      if (k == 0) begin : g_first
         assign valid_prev = da_valid;
         assign p_prev     = {1'b1, 32'h0};
         assign n_prev     = da_dz ? '0 : da_quo[PROD_W-1:FRAC_W];
         assign f_prev     = da_dz ? '0 : da_quo[FRAC_W-1:0];
      end else begin : g_next
         assign valid_prev = ex_valid_ff[k-1];
         assign p_prev     = ex_p_ff[k-1];
         assign n_prev     = ex_n_ff[k-1];
         assign f_prev     = ex_f_ff[k-1];
      end

      always_comb begin
         mul  = 65'(p_prev) * 65'(COEF);
         p_in = f_prev[FRAC_W-1-k] ? mul[64:32] : p_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ex_valid_ff[k] <= 1'b0;
         end else if (en) begin
            ex_valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ex_p_ff[k] <= p_in;
            ex_n_ff[k] <= n_prev;
            ex_f_ff[k] <= f_prev;
         end
      end
   end

   // shift, rotation count
   logic              s_valid_ff;
   logic [BASE_W-1:0] s_base_ff;
   logic              r1_valid_ff;
   logic [BASE_W-1:0] r1_base_ff;
   logic [31:0]       r1_t_ff;
   logic              r2_valid_ff;
   logic [BASE_W-1:0] r2_base_ff;
   logic [ROT_W-1:0]  r2_rot_ff;
   logic [53:0]       oc_mul;
   logic [61:0]       k_mul;
   logic [EXPN_W-1:0] sh_n;
   logic [BASE_W-1:0] sh_p;

   always_comb begin
      sh_n   = ex_n_ff[FRAC_W-1];
      sh_p   = ex_p_ff[FRAC_W-1];
      oc_mul = 54'(orig_ctx_ff) * 54'(s_base_ff);
      k_mul  = 62'(r1_t_ff) * 62'(INV_TWO_PI);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff  <= 1'b0;
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
      end else if (en) begin
         s_valid_ff  <= ex_valid_ff[FRAC_W-1];
         r1_valid_ff <= s_valid_ff;
         r2_valid_ff <= r1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_base_ff  <= (sh_n >= EXPN_W'(BASE_W)) ? '0 : (sh_p >> sh_n[5:0]);
         r1_base_ff <= s_base_ff;
         r1_t_ff    <= oc_mul[53:22];
         r2_base_ff <= r1_base_ff;
         r2_rot_ff  <= k_mul[61:34];
      end
   end

   logic                   db_valid;
   logic [DIVB_NUM_W-1:0]  db_quo;
   logic [DIVB_SIDE_W-1:0] db_side;

   yrif_div #(.NUM_W(DIVB_NUM_W), .DEN_W(Q8_W), .SIDE_W(DIVB_SIDE_W)) u_div_lin (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (r2_valid_ff),
      .in_num   ({r2_base_ff, 8'h0}),
      .in_den   (scale_ff),
      .in_side  ({r2_base_ff, r2_rot_ff}),
      .out_valid(db_valid),
      .out_quo  (db_quo),
      .out_side (db_side)
   );

   // region select, blend product
   logic              c_valid_ff;
   mode_type          c_mode_ff;
   logic [BASE_W-1:0] c_base_ff;
   logic [BASE_W-1:0] c_lin_ff;
   logic [BASE_W-1:0] c_diff_ff;
   logic [Q8_W-1:0]   c_dr_ff;
   logic              m_valid_ff;
   mode_type          m_mode_ff;
   logic [BASE_W-1:0] m_base_ff;
   logic [BASE_W-1:0] m_lin_ff;
   logic [DIVC_NUM_W-1:0] m_prod_ff;
   logic [BASE_W-1:0] b_base;
   logic [BASE_W-1:0] b_lin;
   logic [ROT_W-1:0]  b_rot;
   mode_type          mode_in;

   always_comb begin
      b_base = db_side[DIVB_SIDE_W-1:ROT_W];
      b_rot  = db_side[ROT_W-1:0];
      b_lin  = db_quo[BASE_W-1:0];
      if (scale_ff <= Q8_W'(ONE_Q8)) begin
         mode_in = MODE_KEEP;
      end else if (b_rot >= ROT_W'(rot_hi_ff)) begin
         mode_in = MODE_KEEP;
      end else if (b_rot <= ROT_W'(rot_lo_ff)) begin
         mode_in = MODE_LIN;
      end else begin
         mode_in = MODE_BLEND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= db_valid;
         m_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_mode_ff <= mode_in;
         c_base_ff <= b_base;
         c_lin_ff  <= b_lin;
         c_diff_ff <= b_base - b_lin;
         c_dr_ff   <= rot_hi_ff - b_rot[Q8_W-1:0];
         m_mode_ff <= c_mode_ff;
         m_base_ff <= c_base_ff;
         m_lin_ff  <= c_lin_ff;
         m_prod_ff <= DIVC_NUM_W'(c_diff_ff) * DIVC_NUM_W'(c_dr_ff);
      end
   end

   logic                   dc_valid;
   logic [DIVC_NUM_W-1:0]  dc_quo;
   logic [DIVC_SIDE_W-1:0] dc_side;

   yrif_div #(.NUM_W(DIVC_NUM_W), .DEN_W(Q8_W), .SIDE_W(DIVC_SIDE_W)) u_div_blend (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (m_valid_ff),
      .in_num   (m_prod_ff),
      .in_den   (rot_hi_ff - rot_lo_ff),
      .in_side  ({m_mode_ff, m_base_ff, m_lin_ff}),
      .out_valid(dc_valid),
      .out_quo  (dc_quo),
      .out_side (dc_side)
   );

   // result select, output register and skid entry
   mode_type          f_mode;
   logic [BASE_W-1:0] f_base;
   logic [BASE_W-1:0] f_lin;
   logic [BASE_W-1:0] f_res;
   logic [OUT_W-1:0]  p_data;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [OUT_W-1:0]  out_data_ff;
   logic [OUT_W-1:0]  out_data_in;
   logic              skid_valid_in;
   logic [OUT_W-1:0]  skid_data_ff;
   logic [OUT_W-1:0]  skid_data_in;

   always_comb begin
      f_mode = mode_type'(dc_side[DIVC_SIDE_W-1:2*BASE_W]);
      f_base = dc_side[2*BASE_W-1:BASE_W];
      f_lin  = dc_side[BASE_W-1:0];
      case (f_mode)
         MODE_KEEP:  f_res = f_base;
         MODE_LIN:   f_res = f_lin;
         MODE_BLEND: f_res = f_base - dc_quo[BASE_W-1:0];
         default:    f_res = f_base;
      endcase
      p_data = f_res[BASE_W-1:1];

      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = dc_valid;
            out_data_in  = p_data;
         end
      end else if (dc_valid && en) begin
         skid_valid_in = 1'b1;
         skid_data_in  = p_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `ASSERT_CLK(a_skid_behind_out, skid_valid_ff |-> out_valid_ff, "skid full with output empty")
   `ASSERT_CLK(a_theta_blocks_req, theta_wr |=> !req_tready, "request taken during log2 update")
   `ASSERT_CLK(a_result_sat, rsp_tvalid |-> (rsp_tdata <= 32'h8000_0000), "result above 1.0")
   `ASSERT_ANY(a_reset_blocks_req, reset |=> !req_tready, "request taken right after reset")

endmodule
